### hw/rtl/sha1mh_pkg.sv
// Shared types and constants of the SHA-1 message hasher.
// No dependencies; the controller, datapath and top level refer to it by scoped names.
package sha1mh_pkg;

    localparam int BLOCK_BYTES   = 64;
    localparam int LEN_FIELD_POS = 56;
    localparam int ROUND_COUNT   = 80;
    localparam int DIGEST_WORDS  = 5;

    // Byte position inside the 64-byte block
    typedef logic [5:0] pos_t;
    // Round counter
    typedef logic [6:0] round_t;
    // Digest word index
    typedef logic [2:0] word_idx_t;

    localparam pos_t      POS_LAST   = pos_t'(BLOCK_BYTES - 1);
    localparam pos_t      POS_LEN    = pos_t'(LEN_FIELD_POS);
    localparam round_t    ROUND_LAST = round_t'(ROUND_COUNT - 1);
    localparam word_idx_t WORD_LAST  = word_idx_t'(DIGEST_WORDS - 1);

    // Source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        BSEL_MSG,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_en;
        logic [2:0] len_idx;
        logic      load_work;
        logic      round_en;
        round_t    round_idx;
        logic      add_hash;
        logic      clear_state;
        word_idx_t out_idx;
        logic      out_last;
    } cmd_t;

endpackage

### hw/rtl/sha1mh_in_if.sv
// Input channel of the SHA-1 hasher: at most one message byte per beat.
// No dependencies.
interface sha1mh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, message_byte, has_byte, is_last, input ready);
    modport sink   (input valid, message_byte, has_byte, is_last, output ready);
endinterface

### hw/rtl/sha1mh_out_if.sv
// Output channel of the SHA-1 hasher: one digest word per beat.
// No dependencies.
interface sha1mh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### hw/rtl/sha1mh_datapath.sv
// Datapath of the SHA-1 hasher: block buffer / schedule window, round logic,
// chaining state and byte counter. Depends on sha1mh_pkg.
module sha1mh_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha1mh_pkg::cmd_t  cmd,
    input  logic [7:0]        message_byte,
    output logic [31:0]       digest_word
);

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam logic [4:0][31:0] INIT_H = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam sha1mh_pkg::round_t STAGE1_END = 7'd20;
    localparam sha1mh_pkg::round_t STAGE2_END = 7'd40;
    localparam sha1mh_pkg::round_t STAGE3_END = 7'd60;

    // word 15 is the oldest word (first bytes of the block)
    logic [15:0][31:0] window_reg, window_next;
    logic [4:0][31:0]  work_reg, work_next;
    logic [4:0][31:0]  hash_reg, hash_next;
    logic [60:0]       count_reg, count_next;

    logic [7:0][7:0]   len_bytes;
    logic [7:0]        sel_byte;
    logic [31:0]       w_cur, w_new, f_val, k_val, t_sum;
    logic [31:0]       a, b, c, d, e;

    // Byte source for the block buffer
    always_comb
    begin
        len_bytes = {count_reg, 3'b000};
        case (cmd.byte_sel)
            sha1mh_pkg::BSEL_MSG:  sel_byte = message_byte;
            sha1mh_pkg::BSEL_MARK: sel_byte = PAD_MARK;
            sha1mh_pkg::BSEL_ZERO: sel_byte = 8'h00;
            sha1mh_pkg::BSEL_LEN:  sel_byte = len_bytes[~cmd.len_idx];
            default:               sel_byte = 8'h00;
        endcase
    end

    // One round of the compression
    always_comb
    begin
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        d = work_reg[3];
        e = work_reg[4];
        w_cur = window_reg[15];
        // W[t+16] from W[t+13], W[t+8], W[t+2] and W[t]
        w_new = window_reg[2] ^ window_reg[7] ^ window_reg[13] ^ window_reg[15];
        w_new = {w_new[30:0], w_new[31]};
        if (cmd.round_idx < STAGE1_END)
        begin
            f_val = (b & c) | (~b & d);
            k_val = K0;
        end
        else if (cmd.round_idx < STAGE2_END)
        begin
            f_val = b ^ c ^ d;
            k_val = K1;
        end
        else if (cmd.round_idx < STAGE3_END)
        begin
            f_val = (b & c) | (b & d) | (c & d);
            k_val = K2;
        end
        else
        begin
            f_val = b ^ c ^ d;
            k_val = K3;
        end
        t_sum = {a[26:0], a[31:27]} + f_val + e + w_cur + k_val;
    end

    // Next-state selection
    always_comb
    begin
        window_next = window_reg;
        work_next   = work_reg;
        hash_next   = hash_reg;
        count_next  = count_reg;

        if (cmd.shift_en)
            window_next = {window_reg[15][23:0], window_reg[14:0], sel_byte};
        else if (cmd.round_en)
            window_next = {window_reg[14:0], w_new};

        if (cmd.load_work)
            work_next = hash_reg;
        else if (cmd.round_en)
            work_next = {d, c, {b[1:0], b[31:2]}, a, t_sum};

        if (cmd.clear_state)
            hash_next = INIT_H;
        else if (cmd.add_hash)
        begin
            for (int i = 0; i < sha1mh_pkg::DIGEST_WORDS; i++)
                hash_next[i] = hash_reg[i] + work_reg[i];
        end

        if (cmd.clear_state)
            count_next = '0;
        else if (cmd.count_en)
            count_next = count_reg + 61'd1;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        work_reg   <= work_next;
    end

    // Chaining state and length counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= INIT_H;
            count_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
        end
    end

    assign digest_word = hash_reg[cmd.out_idx];

endmodule

### hw/rtl/sha1mh_ctrl.sv
// Controller of the SHA-1 hasher: byte gathering, padding sequence,
// round counting and digest output. Depends on sha1mh_pkg.
module sha1mh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_has_byte,
    input  logic             in_is_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sha1mh_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_LOAD,
        ST_ROUNDS,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    sha1mh_pkg::pos_t      pos_reg, pos_next;
    sha1mh_pkg::round_t    round_reg, round_next;
    sha1mh_pkg::word_idx_t idx_reg, idx_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pos_next   = pos_reg;
        round_next = round_reg;
        idx_next   = idx_reg;

        cmd             = '0;
        cmd.byte_sel    = sha1mh_pkg::BSEL_MSG;
        cmd.len_idx     = pos_reg[2:0];
        cmd.round_idx   = round_reg;
        cmd.out_idx     = idx_reg;
        cmd.out_last    = (idx_reg == sha1mh_pkg::WORD_LAST);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_has_byte)
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.count_en = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                        if (pos_reg == sha1mh_pkg::POS_LAST)
                        begin
                            state_next = ST_LOAD;
                            ret_next   = in_is_last ? ST_MARK : ST_IDLE;
                        end
                        else if (in_is_last)
                            state_next = ST_MARK;
                    end
                    else if (in_is_last)
                        state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha1mh_pkg::BSEL_MARK;
                pos_next     = pos_reg + 6'd1;
                if (pos_reg == sha1mh_pkg::POS_LAST)
                begin
                    state_next = ST_LOAD;
                    ret_next   = ST_ZERO;
                end
                else
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (pos_reg == sha1mh_pkg::POS_LEN)
                    state_next = ST_LEN;
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = sha1mh_pkg::BSEL_ZERO;
                    pos_next     = pos_reg + 6'd1;
                    if (pos_reg == sha1mh_pkg::POS_LAST)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = ST_ZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = sha1mh_pkg::BSEL_LEN;
                pos_next     = pos_reg + 6'd1;
                if (pos_reg == sha1mh_pkg::POS_LAST)
                begin
                    state_next = ST_LOAD;
                    ret_next   = ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUNDS;
            end
            ST_ROUNDS:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 7'd1;
                if (round_reg == sha1mh_pkg::ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_hash = 1'b1;
                state_next   = ret_reg;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == sha1mh_pkg::WORD_LAST)
                    begin
                        cmd.clear_state = 1'b1;
                        idx_next        = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            pos_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    // Digest goes out only on a block boundary
    a_pos_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg == '0))
        else $error("digest output with partial block buffered");

    // Round counter stays within the round range
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS) |-> (round_reg <= sha1mh_pkg::ROUND_LAST))
        else $error("round counter out of range");

    // Last round is followed by the chaining update
    a_rounds_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS && round_reg == sha1mh_pkg::ROUND_LAST)
        |=> (state_reg == ST_ADD))
        else $error("chaining update skipped");

    // After the fifth word the block takes input again with a fresh count
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && idx_reg == sha1mh_pkg::WORD_LAST)
        |=> (in_ready && idx_reg == '0))
        else $error("no return to idle after digest");

    // Word index never passes the last digest word
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= sha1mh_pkg::WORD_LAST)
        else $error("digest word index out of range");

endmodule

### hw/rtl/sha1_message_hasher_unit.sv
// Top level of the SHA-1 message hasher: controller plus datapath.
// Depends on sha1mh_pkg, sha1mh_in_if, sha1mh_out_if, sha1mh_ctrl, sha1mh_datapath.
//
//   channel     dir  beat payload                               handshake
//   msg_in      in   message_byte[7:0], has_byte, is_last       valid/ready
//   digest_out  out  digest_word[31:0], word_index[2:0], last   valid/ready
//
// Byte beats are taken one per cycle while msg_in is ready; every 64th message
// byte starts a compression of the block (work load, 80 rounds, chaining add),
// one round per cycle. On is_last the padding is shifted in one byte per cycle
// up to the block end, the zero fill passing to the length field without a shift
// (one or two blocks, each followed by a compression); then five beats.
// msg_in is not ready during compression, padding and digest output.
// digest_out holds each word until taken. Reset is asynchronous, active low,
// and loads the standard initial chaining values.
module sha1_message_hasher_unit (
    input  logic         clk,
    input  logic         rst_n,
    sha1mh_in_if.sink    msg_in,
    sha1mh_out_if.source digest_out
);

    sha1mh_pkg::cmd_t cmd;

    sha1mh_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (msg_in.valid),
        .in_has_byte (msg_in.has_byte),
        .in_is_last  (msg_in.is_last),
        .in_ready    (msg_in.ready),
        .out_valid   (digest_out.valid),
        .out_ready   (digest_out.ready),
        .cmd         (cmd)
    );

    sha1mh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_byte (msg_in.message_byte),
        .digest_word  (digest_out.digest_word)
    );

    assign digest_out.word_index = cmd.out_idx;
    assign digest_out.last_word  = cmd.out_last;

endmodule
